[sv/ltile_pkg.sv]
// ----------------------------------------------------------------------------
// ltile_pkg: shared types, command codes and helpers for the life tile
// Holds the command byte codes, the frame row type used by the row lanes
// and the ring byte extraction helpers.
// ----------------------------------------------------------------------------
package ltile_pkg;

   // Command byte codes
   localparam logic [7:0] OP_LOAD = 8'h01;
   localparam logic [7:0] OP_NEXT = 8'h02;
   localparam logic [7:0] OP_EDGE = 8'h06;

   // Tile geometry
   localparam int unsigned ROWS     = 8;
   localparam int unsigned COLS     = 8;
   localparam int unsigned RING_W   = 40;
   localparam int unsigned FRAME_W  = COLS + 2;
   localparam int unsigned FRAME_H  = ROWS + 2;

   // One row of the 10x10 frame: bit 9 is the left border, bit 0 the right,
   // tile bit b sits at bit b+1.
   typedef logic [FRAME_W-1:0] frame_row_type;
   typedef logic [COLS-1:0]    tile_row_type;
   typedef logic [RING_W-1:0]  ring_type;

   // Ring byte k (k = 3..7) of the stored border
   function automatic logic [7:0] ring_byte(input ring_type ring, input int unsigned k);
      logic [7:0] b;
      b = ring[8*(k-3) +: 8];
      return b;
   endfunction

endpackage

[sv/ltile_row_lane.sv]
// ----------------------------------------------------------------------------
// ltile_row_lane: next-generation logic for one tile row
// Counts the eight neighbors of each of the row's cells from the frame rows
// above, at and below it, and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
module ltile_row_lane (
   input  ltile_pkg::frame_row_type above,
   input  ltile_pkg::frame_row_type mid,
   input  ltile_pkg::frame_row_type below,
   output ltile_pkg::tile_row_type  row_next
);

   // Per-cell neighbor count and rule
   always_comb begin
      logic [3:0] n;
      row_next = '0;
      for (int b = 0; b < int'(ltile_pkg::COLS); b++) begin
         n = 4'(above[b]) + 4'(above[b+1]) + 4'(above[b+2])
           + 4'(below[b]) + 4'(below[b+1]) + 4'(below[b+2])
           + 4'(mid[b])   + 4'(mid[b+2]);
         row_next[b] = (n == 4'd3) || ((n == 4'd2) && mid[b+1]);
      end
   end

endmodule

[sv/ltile_next_gen.sv]
// ----------------------------------------------------------------------------
// ltile_next_gen: one life generation over the whole tile
// Builds the 10x10 frame from the tile and the border ring, runs one lane
// per row and merges the lane results into the new tile.
// ----------------------------------------------------------------------------
module ltile_next_gen (
   input  logic [63:0]         tile,
   input  ltile_pkg::ring_type ring,
   output logic [63:0]         tile_next
);

   ltile_pkg::frame_row_type frame [ltile_pkg::FRAME_H];
   ltile_pkg::tile_row_type  lane_row [ltile_pkg::ROWS];
   logic [7:0] e3, e4, e5, e6, e7;

   assign e3 = ltile_pkg::ring_byte(ring, 3);
   assign e4 = ltile_pkg::ring_byte(ring, 4);
   assign e5 = ltile_pkg::ring_byte(ring, 5);
   assign e6 = ltile_pkg::ring_byte(ring, 6);
   assign e7 = ltile_pkg::ring_byte(ring, 7);

   // Frame assembly: border cells placed around the tile rows
   always_comb begin
      // top row: e7 reversed on the left eight, then e6 bits 0 and 1
      for (int i = 0; i < 8; i++) begin
         frame[0][2+i] = e7[7-i];
      end
      frame[0][1] = e6[0];
      frame[0][0] = e6[1];
      // tile rows
      for (int j = 0; j < int'(ltile_pkg::ROWS); j++) begin
         frame[j+1][ltile_pkg::COLS:1] = tile[8*j +: 8];
      end
      // left border: e3 bits 3..0 on the upper rows, e4 bits 7..4 below
      for (int j = 0; j < 4; j++) begin
         frame[j+1][ltile_pkg::FRAME_W-1] = e3[3-j];
         frame[j+5][ltile_pkg::FRAME_W-1] = e4[7-j];
      end
      // right border: e6 bits 2..7 on the upper six rows, e5 bits 0..1 below
      for (int j = 0; j < 6; j++) begin
         frame[j+1][0] = e6[2+j];
      end
      frame[7][0] = e5[0];
      frame[8][0] = e5[1];
      // bottom row: e4 low nibble on the left, e5 bits 7..2 on the right
      frame[ltile_pkg::FRAME_H-1] = {e4[3:0], e5[7:2]};
   end

   // One lane per row
   for (genvar r = 0; r < int'(ltile_pkg::ROWS); r++) begin : g_lane
      ltile_row_lane u_lane (
         .above    (frame[r]),
         .mid      (frame[r+1]),
         .below    (frame[r+2]),
         .row_next (lane_row[r])
      );
   end

   // Merge lane rows into the tile word
   always_comb begin
      for (int r = 0; r < int'(ltile_pkg::ROWS); r++) begin
         tile_next[8*r +: 8] = lane_row[r];
      end
   end

endmodule

[sv/life_tile_with_edge_ring_unit.sv]
// ----------------------------------------------------------------------------
// life_tile_with_edge_ring_unit: 8x8 B3/S23 life tile with stored border
// Top level: command decode, tile and ring state, output register and skid.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready, req_op, req_sdu) carries one
//   command per transfer: op 1 loads the tile from the payload turned by
//   180 degrees, op 6 stores payload bytes 3..7 as the border ring, op 2
//   advances the tile one generation across the ring; other ops leave state.
//   Response channel (rsp_valid/rsp_ready, rsp_grid_out) returns one
//   transfer per request: the tile as it stands after that command.
//   The response is registered in the output register, or in the skid
//   register while the receiver stalls. Throughput is one command per cycle
//   unless the skid is full; eight combinational row lanes form a generation.
//   When the receiver stalls, one further request is taken into a skid
//   register; req_ready drops only while the skid register is full.
//   Synchronous reset clears the tile (all dead), the ring and both valid
//   flags; responses in flight are dropped.
// ----------------------------------------------------------------------------
module life_tile_with_edge_ring_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_op,
   input  logic [63:0] req_sdu,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_grid_out
);

   logic [63:0]         tile_ff, tile_in;
   ltile_pkg::ring_type ring_ff, ring_in;
   logic [63:0]         gen_tile;
   logic [63:0]         load_tile;
   logic                out_valid_ff, out_valid_in;
   logic [63:0]         out_data_ff, out_data_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [63:0]         skid_data_ff, skid_data_in;
   logic                accept, pop;

   assign req_ready    = !skid_valid_ff;
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = out_valid_ff;
   assign rsp_grid_out = out_data_ff;
   assign pop          = out_valid_ff && rsp_ready;

   // Generation core
   ltile_next_gen u_next_gen (
      .tile      (tile_ff),
      .ring      (ring_ff),
      .tile_next (gen_tile)
   );

   // Load path: full 64-bit bit reversal
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         load_tile[i] = req_sdu[63-i];
      end
   end

   // Command decode
   always_comb begin
      tile_in = tile_ff;
      ring_in = ring_ff;
      if (accept) begin
         case (req_op)
            ltile_pkg::OP_LOAD: tile_in = load_tile;
            ltile_pkg::OP_EDGE: ring_in = req_sdu[63:24];
            ltile_pkg::OP_NEXT: tile_in = gen_tile;
            default: ;
         endcase
      end
   end

   // Output register and skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = tile_in;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = tile_in;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_ff       <= '0;
         ring_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         tile_ff       <= tile_in;
         ring_ff       <= ring_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
